// File: hdl/first_fit_free_list_allocator_assert.svh
// ---------------------------------------------------------------------------
// First-fit free-list allocator assertion macros
// Concurrent check macros shared by the allocator RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hdl/ffa_pkg.sv
// ---------------------------------------------------------------------------
// First-fit free-list allocator package
// Shared codes, reset values and the controller-to-datapath command type.
// ---------------------------------------------------------------------------
package ffa_pkg;

  // request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_SPACE = 2'd1;
  localparam logic [1:0] STATUS_LIST_FULL    = 2'd2;

  // configuration map
  localparam int unsigned APB_ADDR_W      = 3;
  localparam logic        REG_HEAP_SIZE   = 1'b0;   // word index of heap_size
  localparam logic [31:0] HEAP_SIZE_RESET = 32'd65536;

  // controller commands to the datapath
  typedef struct packed {
    logic load;     // capture the accepted request word
    logic scan;     // register first-fit compare and bump check
    logic commit;   // update list and bump pointer, emit result
  } cmd_t;

endpackage

// File: hdl/ffa_datapath.sv
// ---------------------------------------------------------------------------
// First-fit free-list allocator datapath
// Free-list register array, parallel first-fit compare, update and shift.
// ---------------------------------------------------------------------------
`include "first_fit_free_list_allocator_assert.svh"

module ffa_datapath #(
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned OFFSET_BITS  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffa_pkg::cmd_t   cmd_i,
  input  logic            in_func_i,
  input  logic [31:0]     in_size_i,
  input  logic [31:0]     in_offs_i,
  input  logic [31:0]     heap_size_i,
  output logic [31:0]     res_offset_o,
  output logic [1:0]      res_status_o
);

  localparam int unsigned N  = FREE_ENTRIES;
  localparam int unsigned W  = OFFSET_BITS;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned BW = (W + 1 > 33) ? W + 1 : 33;

  // request word
  logic          func_q;
  logic [W-1:0]  size_q;
  logic [W-1:0]  offs_q;

  // free list and pointers
  logic [W-1:0]  base_q [N];
  logic [W-1:0]  len_q  [N];
  logic [CW-1:0] count_q;
  logic [W-1:0]  bump_q;

  // scan results
  logic [N-1:0]  first_q;
  logic          any_q;
  logic          exact_q;
  logic [W-1:0]  selb_q;
  logic [W-1:0]  sell_q;
  logic          fits_q;
  logic [W-1:0]  bump_sum_q;

  logic [N-1:0]  eq_vec;
  logic [N-1:0]  gt_vec;
  logic [N-1:0]  hit_vec;
  logic [N-1:0]  first_vec;
  logic [W-1:0]  selb;
  logic [W-1:0]  sell;
  logic [W:0]    bump_sum;
  logic [BW-1:0] heap_ext;
  logic [BW-1:0] cap;
  logic [BW-1:0] bound;
  logic          fits;

  logic [N-1:0]  ge_vec;
  logic [W-1:0]  new_len;
  logic [W-1:0]  carve;
  logic          full;
  logic          do_remove;
  logic          do_shrink;
  logic          do_bump;
  logic          do_append;
  logic [W-1:0]  res_w;

  // first-fit compare over all live entries
  always_comb begin
    selb = '0;
    sell = '0;
    for (int i = 0; i < N; i++) begin
      eq_vec[i] = (CW'(i) < count_q) && (len_q[i] == size_q);
      gt_vec[i] = (CW'(i) < count_q) && (len_q[i] > size_q);
    end
    hit_vec   = eq_vec | gt_vec;
    first_vec = hit_vec & (~hit_vec + N'(1));
    for (int i = 0; i < N; i++) begin
      if (first_vec[i]) begin
        selb = selb | base_q[i];
        sell = sell | len_q[i];
      end
    end
  end

  // bump bound is heap_size capped at the offset range
  always_comb begin
    bump_sum = {1'b0, bump_q} + {1'b0, size_q};
    heap_ext = BW'(heap_size_i);
    cap      = BW'(1) << W;
    bound    = (heap_ext > cap) ? cap : heap_ext;
    fits     = BW'(bump_sum) <= bound;
  end

  always_comb begin
    ge_vec    = ~(first_q - N'(1));
    new_len   = sell_q - size_q;
    carve     = selb_q + sell_q - size_q;
    full      = (count_q == CW'(N));
    do_remove = cmd_i.commit && (func_q == ffa_pkg::FUNC_ALLOC) && any_q && exact_q;
    do_shrink = cmd_i.commit && (func_q == ffa_pkg::FUNC_ALLOC) && any_q && !exact_q;
    do_bump   = cmd_i.commit && (func_q == ffa_pkg::FUNC_ALLOC) && !any_q && fits_q;
    do_append = cmd_i.commit && (func_q == ffa_pkg::FUNC_FREE) && !full;
  end

  always_comb begin
    res_w        = '0;
    res_status_o = ffa_pkg::STATUS_OK;
    if (func_q == ffa_pkg::FUNC_FREE) begin
      if (full) res_status_o = ffa_pkg::STATUS_LIST_FULL;
    end else if (any_q) begin
      res_w = exact_q ? selb_q : carve;
    end else if (fits_q) begin
      res_w = bump_q;
    end else begin
      res_status_o = ffa_pkg::STATUS_OUT_OF_SPACE;
    end
    res_offset_o = 32'(res_w);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      size_q <= W'(in_size_i);
      offs_q <= W'(in_offs_i);
    end
    if (cmd_i.scan) begin
      first_q    <= first_vec;
      any_q      <= |hit_vec;
      exact_q    <= |(first_vec & eq_vec);
      selb_q     <= selb;
      sell_q     <= sell;
      fits_q     <= fits;
      bump_sum_q <= bump_sum[W-1:0];
    end
    // close the gap left by a removed entry
    if (do_remove) begin
      for (int j = 0; j < N - 1; j++) begin
        if (ge_vec[j]) begin
          base_q[j] <= base_q[j+1];
          len_q[j]  <= len_q[j+1];
        end
      end
    end
    if (do_shrink) begin
      for (int j = 0; j < N; j++) begin
        if (first_q[j]) len_q[j] <= new_len;
      end
    end
    if (do_append) begin
      for (int j = 0; j < N; j++) begin
        if (count_q == CW'(j)) begin
          base_q[j] <= offs_q;
          len_q[j]  <= size_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bump_q  <= '0;
    end else begin
      if (do_remove) count_q <= count_q - CW'(1);
      else if (do_append) count_q <= count_q + CW'(1);
      if (do_bump) bump_q <= bump_sum_q;
    end
  end

  `FFA_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(N),
    "free list count beyond capacity")
  `FFA_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, do_append,
    count_q == $past(count_q) + CW'(1), "append did not grow the list")

endmodule

// File: hdl/ffa_ctrl.sv
// ---------------------------------------------------------------------------
// First-fit free-list allocator controller
// Sequences accept, scan and commit for one request at a time.
// ---------------------------------------------------------------------------
`include "first_fit_free_list_allocator_assert.svh"

module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  output ffa_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    in_ready_o   = (state_q == S_IDLE) || ((state_q == S_COMMIT) && out_free_i);
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_COMMIT) && out_free_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) state_d = S_SCAN;
      end
      S_SCAN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output word is free
        if (out_free_i) state_d = cmd_o.load ? S_SCAN : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FFA_ASSERT_NEXT(a_load_scans, clk_i, rst_ni, cmd_o.load, state_q == S_SCAN,
    "accepted word not followed by scan")
  `FFA_ASSERT_NEXT(a_scan_commits, clk_i, rst_ni, cmd_o.scan, state_q == S_COMMIT,
    "scan not followed by commit")

endmodule

// File: hdl/first_fit_free_list_allocator.sv
// ---------------------------------------------------------------------------
// First-fit free-list allocator
// Offset allocator for one heap: first-fit free list with bump fallback.
// ---------------------------------------------------------------------------
//  port group  dir  word contents
//  s_axis      in   tuser[0] func, tdata[31:0] req_size, tdata[63:32] free_offset
//  m_axis      out  tdata[31:0] result_offset, tdata[33:32] status
//  apb         cfg  byte address 0: heap_size
//
//  Each request passes a scan state, which compares all free-list entries in
//  parallel and registers the first fit, then an update cycle, which changes the
//  list or the bump pointer. The next word is accepted in the update cycle.
//  Reset clears the entry count and the bump pointer; no clearing pass.
//  The update cycle stalls while the output word is held by m_axis_tready.
// ---------------------------------------------------------------------------
`include "first_fit_free_list_allocator_assert.svh"

module first_fit_free_list_allocator #(
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned OFFSET_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // req_size, free_offset
  input  logic [0:0]                    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // result_offset, status
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ffa_pkg::cmd_t cmd;
  logic          out_free;
  logic [31:0]   heap_q;
  logic [31:0]   res_offset;
  logic [1:0]    res_status;
  logic          m_valid_q;
  logic [39:0]   m_data_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffa_pkg::REG_HEAP_SIZE) ? heap_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= ffa_pkg::HEAP_SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ffa_pkg::REG_HEAP_SIZE)) begin
      heap_q <= pwdata;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  ffa_datapath #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_func_i    (s_axis_tuser[0]),
    .in_size_i    (s_axis_tdata[31:0]),
    .in_offs_i    (s_axis_tdata[63:32]),
    .heap_size_i  (heap_q),
    .res_offset_o (res_offset),
    .res_status_o (res_status)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) m_data_q <= {6'd0, res_status, res_offset};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `FFA_ASSERT_IMPL(a_commit_slot, clk_i, rst_ni, cmd.commit,
    !m_valid_q || m_axis_tready, "result written over an unread word")

endmodule

// File: bench/ffa_alloc_checker.sv
// ---------------------------------------------------------------------------
// First-fit allocator result checker
// Watches the request, result and register channels, keeps its own copy of
// the free list, bump pointer and heap_size, predicts the answer to every
// accepted request word and compares each result word in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ffa_alloc_checker #(
  parameter int unsigned FREE_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,   // req_size, free_offset
  input  logic [0:0]                     s_axis_tuser,   // func
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [39:0]                    m_axis_tdata,   // result_offset, status
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending,
  output int                             n_ok,
  output int                             n_oos,
  output int                             n_full
);

  localparam logic [ffa_pkg::APB_ADDR_W-1:0] HEAP_SIZE_ADDR =
    {ffa_pkg::REG_HEAP_SIZE, 2'b00};

  typedef struct packed {
    logic [31:0] offset;
    logic [1:0]  status;
  } grant_t;

  logic [31:0] range_base [FREE_ENTRIES];
  logic [31:0] range_len  [FREE_ENTRIES];
  int          range_count = 0;
  logic [31:0] bump_ptr    = '0;
  logic [31:0] heap_limit  = ffa_pkg::HEAP_SIZE_RESET;
  grant_t      grants_due [$];

  int fails = 0;
  int due_cnt = 0;
  int ok_cnt = 0;
  int oos_cnt = 0;
  int full_cnt = 0;

  assign fail_count = fails;
  assign pending    = due_cnt;
  assign n_ok       = ok_cnt;
  assign n_oos      = oos_cnt;
  assign n_full     = full_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    if (fails <= 40) begin
      $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  // first-fit scan, then bump fallback; a free appends unless the list is full
  task automatic serve_request(input logic fn, input logic [31:0] size,
                               input logic [31:0] offs, output grant_t g);
    int  k;
    int  j;
    bit  placed;
    g.offset = '0;
    g.status = ffa_pkg::STATUS_OK;
    placed   = 1'b0;
    if (fn == ffa_pkg::FUNC_FREE) begin
      if (range_count >= FREE_ENTRIES) begin
        g.status = ffa_pkg::STATUS_LIST_FULL;
      end else begin
        range_base[range_count] = offs;
        range_len[range_count]  = size;
        range_count++;
      end
    end else begin
      for (k = 0; k < range_count && !placed; k++) begin
        if (range_len[k] == size) begin
          g.offset = range_base[k];
          // close the gap, keeping the order of the rest
          for (j = k; j + 1 < range_count; j++) begin
            range_base[j] = range_base[j+1];
            range_len[j]  = range_len[j+1];
          end
          range_count--;
          placed = 1'b1;
        end else if (range_len[k] > size) begin
          // carve from the top of the entry
          range_len[k] = range_len[k] - size;
          g.offset     = range_base[k] + range_len[k];
          placed       = 1'b1;
        end
      end
      if (!placed) begin
        if ({1'b0, bump_ptr} + {1'b0, size} > {1'b0, heap_limit}) begin
          g.status = ffa_pkg::STATUS_OUT_OF_SPACE;
        end else begin
          g.offset = bump_ptr;
          bump_ptr = bump_ptr + size;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      range_count = 0;
      bump_ptr    = '0;
      heap_limit  = ffa_pkg::HEAP_SIZE_RESET;
      grants_due.delete();
    end else begin
      if (psel && penable && pready && paddr == HEAP_SIZE_ADDR) begin
        if (pwrite) begin
          heap_limit = pwdata;
        end else if (prdata !== heap_limit) begin
          report_mismatch("heap_size readback", prdata, heap_limit);
        end
      end
      // compare before predicting: a word leaving now belongs to an older request
      if (m_axis_tvalid && m_axis_tready) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result word with nothing pending", m_axis_tdata[31:0], '0);
        end else begin
          want = grants_due.pop_front();
          if (m_axis_tdata[31:0] !== want.offset) begin
            report_mismatch("result_offset", m_axis_tdata[31:0], want.offset);
          end
          if (m_axis_tdata[33:32] !== want.status) begin
            report_mismatch("status", 32'(m_axis_tdata[33:32]), 32'(want.status));
          end
          if (m_axis_tdata[39:34] !== '0) begin
            report_mismatch("tdata padding", 32'(m_axis_tdata[39:34]), '0);
          end
          case (want.status)
            ffa_pkg::STATUS_OK:           ok_cnt++;
            ffa_pkg::STATUS_OUT_OF_SPACE: oos_cnt++;
            default:                      full_cnt++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        serve_request(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32], want);
        grants_due.insert(grants_due.size(), want);
      end
    end
    due_cnt = grants_due.size();
  end

endmodule

// File: bench/tb_first_fit_free_list_allocator.sv
// ---------------------------------------------------------------------------
// First-fit free-list allocator testbench
// Directed corner words, then phases of random allocate/free traffic under
// several heap_size settings with random source gaps and sink stalls; the
// checker instance predicts and compares every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_free_list_allocator;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 225;
  localparam logic [ffa_pkg::APB_ADDR_W-1:0] HEAP_SIZE_ADDR =
    {ffa_pkg::REG_HEAP_SIZE, 2'b00};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [63:0]                    s_axis_tdata;   // req_size, free_offset
  logic [0:0]                     s_axis_tuser;   // func
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [39:0]                    m_axis_tdata;   // result_offset, status
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ffa_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  int fail_count;
  int pending;
  int n_ok;
  int n_oos;
  int n_full;

  int          gap_mode;
  int          stall_mode;
  int          cycles;
  int          heap_writes;
  int          freed_wr;
  logic [31:0] freed_sizes [8];

  first_fit_free_list_allocator #(
    .FREE_ENTRIES(ENTRIES),
    .OFFSET_BITS (32)
  ) dut (.*);

  ffa_alloc_checker #(.FREE_ENTRIES(ENTRIES)) checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results pending", cycles, pending);
    $display("tb_first_fit_free_list_allocator: FAIL");
    $finish;
  end

  // sink: random stalls, mostly short, a few long
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (stall_mode != 0 && $urandom_range(0, 3 - stall_mode) == 0) begin
          if ($urandom_range(0, 9) < 3 * stall_mode - 2) begin
            stall_left = $urandom_range(8, 30);
          end else begin
            stall_left = $urandom_range(1, 3);
          end
        end
      end
    end
  end

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 85 - 40 * mode) return 0;
    if (r < 95 - 5 * mode) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 64);
    if (r < 88) return $urandom_range(0, 4096);
    if (r < 96) return $urandom;
    case ($urandom_range(0, 2))
      0:       return 32'h0;
      1:       return 32'h1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // entered and left at a falling edge; tvalid stays high into the next word
  task automatic send_word(input logic fn, input logic [31:0] size, input logic [31:0] offs);
    int gap;
    gap = pick_gap(gap_mode);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = fn;
    s_axis_tdata  = {offs, size};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = HEAP_SIZE_ADDR;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_heap(input logic [31:0] value);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    heap_writes++;
  endtask

  // frees feed a pool of sizes so that later allocates can hit them exactly
  task automatic random_word(input int free_pct);
    logic [31:0] size;
    size = pick_size();
    if ($urandom_range(0, 99) < free_pct) begin
      freed_sizes[freed_wr] = size;
      freed_wr = (freed_wr + 1) % 8;
      send_word(ffa_pkg::FUNC_FREE, size, $urandom);
    end else begin
      if ($urandom_range(0, 99) < 40) size = freed_sizes[$urandom_range(0, 7)];
      send_word(ffa_pkg::FUNC_ALLOC, size, $urandom);
    end
  endtask

  initial begin
    logic [31:0] heap_plan [PHASES];
    int          free_plan [PHASES];
    int          gap_plan  [PHASES];
    int          stall_plan[PHASES];
    int          p;
    int          i;
    heap_plan  = '{32'hFFFF_FFFF, 32'h0003_0000, 32'h0, 32'h0, ffa_pkg::HEAP_SIZE_RESET,
                   32'hFFFF_FFFF};
    free_plan  = '{50, 45, 60, 35, 50, 40};
    gap_plan   = '{0, 1, 1, 0, 2, 1};
    stall_plan = '{0, 1, 0, 1, 2, 1};
    heap_plan[3] = $urandom;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ffa_pkg::FUNC_ALLOC;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gap_mode      = 0;
    stall_mode    = 0;
    heap_writes   = 0;
    freed_wr      = 0;
    for (i = 0; i < 8; i++) freed_sizes[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset value of heap_size
    apb_access(1'b0, '0);

    // bump path: zero size on empty list, fill to the bound, then overflow
    send_word(ffa_pkg::FUNC_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_word(ffa_pkg::FUNC_ALLOC, 32'd65536, 32'h0);
    send_word(ffa_pkg::FUNC_ALLOC, 32'h1, 32'h0);
    send_word(ffa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0);
    // a range near the top of the offset space, then a zero-length range
    send_word(ffa_pkg::FUNC_FREE, 32'h20, 32'hFFFF_FFF0);
    send_word(ffa_pkg::FUNC_FREE, 32'h0, 32'h0);
    // zero size ahead of a nonzero entry returns its wrapped end
    send_word(ffa_pkg::FUNC_ALLOC, 32'h0, 32'h0);
    // exact match removes the head, then zero size removes the empty range
    send_word(ffa_pkg::FUNC_ALLOC, 32'h20, 32'h0);
    send_word(ffa_pkg::FUNC_ALLOC, 32'h0, 32'h0);
    // fill the list and overflow it by one
    for (i = 0; i <= ENTRIES; i++) begin
      if (i == 7) begin
        send_word(ffa_pkg::FUNC_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end else begin
        send_word(ffa_pkg::FUNC_FREE, 32'(3 * i + 1), 32'h1000 + 32'(i) * 32'h100);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      drain();
      set_heap(heap_plan[p]);
      gap_mode   = gap_plan[p];
      stall_mode = stall_plan[p];
      for (i = 0; i < PHASE_WORDS; i++) begin
        random_word(free_plan[p]);
        // hold off until the block has answered everything
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);

    $display("covered %0d result words: %0d ok, %0d out_of_space, %0d list_full",
             n_ok + n_oos + n_full, n_ok, n_oos, n_full);
    $display("%0d heap_size settings (zero and all ones among them) under varied gaps/stalls",
             heap_writes);
    if (fail_count == 0) begin
      $display("tb_first_fit_free_list_allocator: PASS");
    end else begin
      $display("tb_first_fit_free_list_allocator: FAIL");
    end
    $finish;
  end

endmodule

// File: first_fit_free_list_allocator.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_datapath.sv
hdl/ffa_ctrl.sv
hdl/first_fit_free_list_allocator.sv
bench/ffa_alloc_checker.sv
bench/tb_first_fit_free_list_allocator.sv
